/* design/flptm_pkg.sv */
// ----------------------------------------------------------------------------
// flptm_pkg
// shared constants, codes and types for the four-level page table block
// ----------------------------------------------------------------------------
package flptm_pkg;

  localparam int TableFramesDef = 64;
  localparam int EntryBits      = 9;
  localparam int AddrW          = 48;
  localparam int DescW          = 64;
  localparam int LevelW         = 2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_ALIGN    = 3'd2,
    ST_MAPPED   = 3'd3,
    ST_UNMAPPED = 3'd4,
    ST_FLAGS    = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ACT_MAP   = 2'd0,
    ACT_XLATE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ZERO,
    S_LINK,
    S_DONE,
    S_ZALL,
    S_INIT
  } walk_state_t;

  // 9-bit table index of a virtual address at a walk level
  function automatic logic [EntryBits-1:0] level_index(input logic [AddrW-1:0] va,
                                                      input logic [LevelW-1:0] lvl);
    logic [AddrW-1:0] sh;
    sh = va >> (6'd39 - 6'(lvl) * 6'd9);
    return sh[EntryBits-1:0];
  endfunction

endpackage

/* design/flptm_ram.sv */
// ----------------------------------------------------------------------------
// flptm_ram
// generic single-port ram, registered read
// ----------------------------------------------------------------------------
module flptm_ram #(
  parameter int Width = 64,
  parameter int Depth = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* design/flptm_walker.sv */
// ----------------------------------------------------------------------------
// flptm_walker
// walk sequencer: reads one descriptor per level through the shared ram port
// ----------------------------------------------------------------------------
module flptm_walker import flptm_pkg::*; #(
  parameter int TableFrames = TableFramesDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  action_t              act,
  input  logic [AddrW-1:0]     va,
  input  logic [AddrW-1:0]     pa,
  input  logic [DescW-1:0]     flags,
  input  logic [AddrW-1:0]     base,
  output logic                 busy,
  output logic                 done,
  output status_t              status,
  output logic [AddrW-1:0]     xaddr,
  input  logic                 done_ack
);
  localparam int FrameW = $clog2(TableFrames);
  localparam int CntW   = $clog2(TableFrames + 1);
  localparam int RamAw  = FrameW + EntryBits;

  walk_state_t          state_r, state_nxt;
  logic [LevelW-1:0]    level_r, level_nxt;
  logic [FrameW-1:0]    frame_r, frame_nxt;
  logic [CntW-1:0]      free_r, free_nxt;
  logic [RamAw-1:0]     zcnt_r, zcnt_nxt;
  status_t              st_r, st_nxt;
  logic [AddrW-1:0]     xa_r, xa_nxt;
  logic [DescW-1:0]     nd_r, nd_nxt;       // descriptor of a new table
  logic [RamAw-1:0]     slot_r, slot_nxt;

  logic                 we;
  logic [RamAw-1:0]     addr;
  logic [DescW-1:0]     wdata, rdata;

  logic [AddrW-1:0]     na, off;
  logic [AddrW-1:0]     desc_a;

  flptm_ram #(.Width(DescW), .Depth(TableFrames << EntryBits)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      free_r  <= CntW'(1);
      zcnt_r  <= '0;
      level_r <= '0;
      frame_r <= '0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      zcnt_r  <= zcnt_nxt;
      level_r <= level_nxt;
      frame_r <= frame_nxt;
      st_r    <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xa_r   <= xa_nxt;
    nd_r   <= nd_nxt;
    slot_r <= slot_nxt;
  end

  // a freshly linked table is followed through its own descriptor
  always_comb begin
    na     = base + {(AddrW-12-FrameW)'(0), free_r[FrameW-1:0], 12'h000};
    desc_a = (state_r == S_LINK) ? {nd_r[AddrW-1:12], 12'h000}
                                 : {rdata[AddrW-1:12], 12'h000};
    off    = (desc_a - base) >> 12;
  end

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    frame_nxt = frame_r;
    free_nxt  = free_r;
    zcnt_nxt  = zcnt_r;
    st_nxt    = st_r;
    xa_nxt    = xa_r;
    nd_nxt    = nd_r;
    slot_nxt  = slot_r;
    we        = 1'b0;
    addr      = slot_r;
    wdata     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          level_nxt = '0;
          frame_nxt = '0;
          xa_nxt    = '0;
          st_nxt    = ST_OK;
          case (act)
            ACT_MAP: begin
              if (va[11:0] != 12'h000 || pa[11:0] != 12'h000) begin
                st_nxt    = ST_ALIGN;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            ACT_XLATE: state_nxt = S_READ;
            ACT_CLEAR: begin
              // sweep the whole store
              free_nxt  = CntW'(1);
              zcnt_nxt  = '0;
              state_nxt = S_ZALL;
            end
            default: begin
              st_nxt    = ST_RANGE;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        slot_nxt  = {frame_r, level_index(va, level_r)};
        addr      = slot_nxt;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (act == ACT_XLATE) begin
          if (!rdata[0]) begin
            st_nxt    = ST_UNMAPPED;
            state_nxt = S_DONE;
          end else if (level_r == 2'd3) begin
            xa_nxt    = {rdata[AddrW-1:12], va[11:0]};
            state_nxt = S_DONE;
          end else if (off >= AddrW'(TableFrames)) begin
            st_nxt    = ST_RANGE;
            state_nxt = S_DONE;
          end else begin
            frame_nxt = off[FrameW-1:0];
            level_nxt = level_r + 2'd1;
            state_nxt = S_READ;
          end
        end else if (!rdata[0]) begin
          if (level_r == 2'd3) begin
            we        = 1'b1;
            wdata     = {16'h0000, pa} | flags;
            state_nxt = S_DONE;
          end else if (free_r >= CntW'(TableFrames)) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else if ((na & flags[AddrW-1:0]) != '0) begin
            st_nxt    = ST_FLAGS;
            state_nxt = S_DONE;
          end else begin
            nd_nxt    = {16'h0000, na} | flags;
            zcnt_nxt  = {free_r[FrameW-1:0], {EntryBits{1'b0}}};
            state_nxt = S_ZERO;
          end
        end else if (level_r == 2'd3) begin
          st_nxt    = ST_MAPPED;
          state_nxt = S_DONE;
        end else if (off >= AddrW'(TableFrames)) begin
          st_nxt    = ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          frame_nxt = off[FrameW-1:0];
          level_nxt = level_r + 2'd1;
          state_nxt = S_READ;
        end
      end
      S_ZERO: begin
        // wipe the new frame one entry a cycle
        we       = 1'b1;
        addr     = zcnt_r;
        wdata    = '0;
        zcnt_nxt = zcnt_r + RamAw'(1);
        if (zcnt_r[EntryBits-1:0] == {EntryBits{1'b1}}) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        // hook the new frame into the parent slot, then follow it
        we       = 1'b1;
        addr     = slot_r;
        wdata    = nd_r;
        free_nxt = free_r + CntW'(1);
        if (off >= AddrW'(TableFrames)) begin
          st_nxt    = ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          frame_nxt = off[FrameW-1:0];
          level_nxt = level_r + 2'd1;
          state_nxt = S_READ;
        end
      end
      S_ZALL, S_INIT: begin
        we       = 1'b1;
        addr     = zcnt_r;
        wdata    = '0;
        zcnt_nxt = zcnt_r + RamAw'(1);
        if (zcnt_r == RamAw'((TableFrames << EntryBits) - 1)) begin
          // the pass after reset returns no word
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (done_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy   = (state_r != S_IDLE);
  assign done   = (state_r == S_DONE);
  assign status = st_r;
  assign xaddr  = (st_r == ST_OK) ? xa_r : '0;

  property p_free_bound;
    @(posedge clk) disable iff (!rst_n) free_r <= CntW'(TableFrames);
  endproperty
  a_free_bound: assert property (p_free_bound) else $error("free frame counter overrun");

  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    done && status != ST_OK |-> xaddr == '0) else $error("address on failed item");

  a_zero_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ZERO |-> free_r < CntW'(TableFrames)) else $error("zeroing beyond store");
endmodule

/* design/four_level_page_table_map_translate_top.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_map_translate_top
// four-level page table keeper: map, translate, clear
// ----------------------------------------------------------------------------
// One word is taken at a time; in_stall stays high until the result word has
// been taken. A map that needs new tables wipes each one through the single
// ram port, one entry a cycle, and then links it. A clear, and the pass after
// reset, sweep the whole store at one entry per cycle, during which no word is
// taken (cfg writes are still accepted).
module four_level_page_table_map_translate_top import flptm_pkg::*; #(
  parameter int TableFrames = TableFramesDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_action,
  input  logic [47:0]      in_virt_addr,
  input  logic [47:0]      in_phys_addr,
  input  logic [63:0]      in_attr_flags,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [47:0]      out_translated_addr,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [47:0]      cfg_table_base
);
  logic [AddrW-1:0]  base_r;
  logic [1:0]        act_r;
  logic [AddrW-1:0]  va_r, pa_r;
  logic [DescW-1:0]  fl_r;
  logic              busy, done, start;
  status_t           st;
  logic [AddrW-1:0]  xa;

  // base only keeps page-aligned bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= {cfg_table_base[47:12], 12'h000};
    end
  end
  assign cfg_ready = 1'b1;

  assign in_stall = busy;
  assign start    = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (start) begin
      act_r <= in_action;
      va_r  <= in_virt_addr;
      pa_r  <= in_phys_addr;
      fl_r  <= in_attr_flags;
    end
  end

  flptm_walker #(.TableFrames(TableFrames)) u_walk (
    .clk(clk), .rst_n(rst_n), .start(start),
    .act(action_t'(start ? in_action : act_r)),
    .va(start ? in_virt_addr : va_r), .pa(start ? in_phys_addr : pa_r),
    .flags(start ? in_attr_flags : fl_r), .base(base_r),
    .busy(busy), .done(done), .status(st), .xaddr(xa),
    .done_ack(!out_stall)
  );

  assign out_valid           = done;
  assign out_status          = st;
  assign out_translated_addr = xa;
endmodule
